// File: rtl/wrl_pkg.sv
// ----------------------------------------------------------------------------
// wrl_pkg
// Shared types, codes and arithmetic for the watershed region labeler.
// ----------------------------------------------------------------------------
package wrl_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int LABEL_W        = 16;
  localparam int TALLY_DEPTH    = 65536;
  localparam int CFG_W          = 9;
  localparam int CFG_IDX_W      = 3;
  localparam logic [LABEL_W-1:0] LABEL_LIMIT = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_SEED_BIAS    = 3'd2,
    REG_GROW_BIAS    = 3'd3,
    REG_EDGE_LIMIT   = 3'd4
  } reg_idx_t;

  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 9'd256;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 9'd256;
  localparam logic [CFG_W-1:0] RST_EDGE_LIMIT   = 9'd20;

  // floor((5*dr + 9*dg + 2*db) / 16), middle minus neighbor
  function automatic logic signed [8:0] bright_diff(input logic [23:0] a,
                                                   input logic [23:0] b);
    logic signed [12:0] dr, dg, db, v;
    dr = $signed({5'b0, a[23:16]}) - $signed({5'b0, b[23:16]});
    dg = $signed({5'b0, a[15:8]}) - $signed({5'b0, b[15:8]});
    db = $signed({5'b0, a[7:0]}) - $signed({5'b0, b[7:0]});
    v  = dr * 13'sd5 + dg * 13'sd9 + db * 13'sd2;
    return v[12:4];
  endfunction

  function automatic logic signed [9:0] add_bias(input logic signed [8:0] d,
                                                input logic [CFG_W-1:0] bias);
    return $signed({d[8], d}) + $signed({bias[8], bias});
  endfunction

endpackage

// File: rtl/wrl_ram.sv
// ----------------------------------------------------------------------------
// wrl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wrl_ram #(
  parameter int W = 16,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/watershed_region_labeler.sv
// ----------------------------------------------------------------------------
// watershed_region_labeler
// Loads an RGB image, segments it into regions by seed scan and FIFO flood,
// and answers label reads.
//
//   channel | direction | handshake             | payload
//   cfg     | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//   in      | in        | in_valid/in_ready     | in_cmd, in_col, in_row_index,
//           |           |                       | in_red, in_green, in_blue
//   out     | out       | out_valid/out_ready   | out_label, out_region_count
//
// Load and no-op answer from idle; a label read goes through S_READ (label RAM read port).
// A run clears max(MAX_WIDTH*MAX_HEIGHT, 65536) addresses; the seed scan reads each
// interior pixel and tests its neighbors, labeling seeds; offsets are summed per region;
// the queue is filled; each flooded pixel tests its in-image and outside neighbors.
// Reset is synchronous, active low; labels read as 0 until the first run.
// A result waiting on out_ready holds in_ready low; one transaction is in flight at a time.
// ----------------------------------------------------------------------------
module watershed_region_labeler #(
  parameter int MAX_WIDTH  = wrl_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = wrl_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wrl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wrl_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_cmd,
  input  logic [7:0]                        in_col,
  input  logic [7:0]                        in_row_index,
  input  logic [7:0]                        in_red,
  input  logic [7:0]                        in_green,
  input  logic [7:0]                        in_blue,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [wrl_pkg::LABEL_W-1:0]       out_label,
  output logic [wrl_pkg::LABEL_W-1:0]       out_region_count
);
  import wrl_pkg::*;

  localparam int SD    = MAX_WIDTH * MAX_HEIGHT;
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = $clog2(SD);
  localparam int CW    = $clog2(SD + 1);
  localparam int TW    = $clog2(TALLY_DEPTH);
  localparam int CLR_N = (SD > TALLY_DEPTH) ? SD : TALLY_DEPTH;
  localparam int KW    = $clog2(CLR_N);
  localparam int XDW   = (($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W) + 1;
  localparam int YDW   = (($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W) + 1;
  localparam int QW    = XW + YW;

  typedef enum logic [17:0] {
    S_IDLE      = 18'b000000000000000001,
    S_READ      = 18'b000000000000000010,
    S_CLEAR     = 18'b000000000000000100,
    S_SEED_MID  = 18'b000000000000001000,
    S_SEED_MIDW = 18'b000000000000010000,
    S_SEED_EVAL = 18'b000000000000100000,
    S_TINC      = 18'b000000000001000000,
    S_PRE_RD    = 18'b000000000010000000,
    S_PRE_WR    = 18'b000000000100000000,
    S_FILL_RD   = 18'b000000001000000000,
    S_FILL_LAB  = 18'b000000010000000000,
    S_FILL_WR   = 18'b000000100000000000,
    S_FL_Q      = 18'b000001000000000000,
    S_FL_C      = 18'b000010000000000000,
    S_FL_CW     = 18'b000100000000000000,
    S_FL_NB     = 18'b001000000000000000,
    S_FL_EV     = 18'b010000000000000000,
    S_DONE      = 18'b100000000000000000
  } state_t;

  localparam logic [1:0] NB_M1 = 2'b11;
  localparam logic [1:0] NB_Z  = 2'b00;
  localparam logic [1:0] NB_P1 = 2'b01;

  function automatic logic [AW-1:0] addr_of(input logic [YW-1:0] y, input logic [XW-1:0] x);
    return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
  endfunction

  state_t st_r, st_nxt;
  logic [CFG_W-1:0] img_w_r, img_h_r, seed_bias_r, grow_bias_r, edge_limit_r;
  logic [XW-1:0] cx_r, cx_nxt;
  logic [YW-1:0] cy_r, cy_nxt;
  logic [1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [23:0] mid_r, mid_nxt;
  logic [LABEL_W-1:0] lab_r, lab_nxt, src_r, src_nxt, cnt_r, cnt_nxt, l_r, l_nxt;
  logic [CW-1:0] sum_r, sum_nxt, head_r, head_nxt, tail_r, tail_nxt;
  logic [KW-1:0] clr_r, clr_nxt;
  logic ran_r, ran_nxt, inside_r, inside_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [LABEL_W-1:0] out_label_r, out_label_nxt, out_cnt_r, out_cnt_nxt;

  logic pix_we, lab_we, tal_we, q_we;
  logic [AW-1:0] pix_waddr, pix_raddr, lab_waddr, lab_raddr, q_waddr, q_raddr;
  logic [23:0] pix_wdata, pix_rdata;
  logic [LABEL_W-1:0] lab_wdata, lab_rdata;
  logic [TW-1:0] tal_waddr, tal_raddr;
  logic [CW-1:0] tal_wdata, tal_rdata;
  logic [QW-1:0] q_wdata, q_rdata;

  logic in_fire, in_inside;
  logic [XDW-1:0] w_eff;
  logic [YDW-1:0] h_eff;
  logic row_end, scan_end, nb_last;
  logic [XW-1:0] cx_adv;
  logic [YW-1:0] cy_adv;
  logic [1:0] dx_adv, dy_adv, dx_i, dy_i;
  logic signed [XDW-1:0] nx_i, nx_c;
  logic signed [YDW-1:0] ny_i, ny_c;
  logic nb_in_c;
  logic [AW-1:0] addr_i, addr_c, addr_ctr;
  logic signed [9:0] seed_v, grow_v;
  logic [LABEL_W-1:0] src_now;

  wrl_ram #(.W(24), .D(SD)) u_pix (
    .clk(clk), .we(pix_we), .waddr(pix_waddr), .wdata(pix_wdata),
    .raddr(pix_raddr), .rdata(pix_rdata)
  );
  wrl_ram #(.W(LABEL_W), .D(SD)) u_lab (
    .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
    .raddr(lab_raddr), .rdata(lab_rdata)
  );
  wrl_ram #(.W(CW), .D(TALLY_DEPTH)) u_tal (
    .clk(clk), .we(tal_we), .waddr(tal_waddr), .wdata(tal_wdata),
    .raddr(tal_raddr), .rdata(tal_rdata)
  );
  wrl_ram #(.W(QW), .D(SD)) u_q (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  assign cfg_ready        = 1'b1;
  assign in_ready         = (st_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire          = in_valid && in_ready;
  assign out_valid        = out_valid_r;
  assign out_label        = out_label_r;
  assign out_region_count = out_cnt_r;

  assign in_inside = (11'(in_col) < 11'(MAX_WIDTH)) && (11'(in_row_index) < 11'(MAX_HEIGHT));
  assign w_eff = (XDW'(img_w_r) > XDW'(MAX_WIDTH)) ? XDW'(MAX_WIDTH) : XDW'(img_w_r);
  assign h_eff = (YDW'(img_h_r) > YDW'(MAX_HEIGHT)) ? YDW'(MAX_HEIGHT) : YDW'(img_h_r);

  assign row_end  = (XDW'(cx_r) == w_eff - XDW'(2));
  assign scan_end = row_end && (YDW'(cy_r) == h_eff - YDW'(2));
  assign cx_adv   = row_end ? XW'(1) : cx_r + XW'(1);
  assign cy_adv   = row_end ? cy_r + YW'(1) : cy_r;
  assign nb_last  = (dx_r == NB_P1) && (dy_r == NB_P1);
  assign dx_adv   = (dx_r == NB_P1) ? NB_M1 : dx_r + 2'd1;
  assign dy_adv   = (dx_r == NB_P1) ? dy_r + 2'd1 : dy_r;

  assign nx_c = $signed(XDW'(cx_r)) + $signed({{(XDW-2){dx_r[1]}}, dx_r});
  assign ny_c = $signed(YDW'(cy_r)) + $signed({{(YDW-2){dy_r[1]}}, dy_r});
  assign nx_i = $signed(XDW'(cx_r)) + $signed({{(XDW-2){dx_i[1]}}, dx_i});
  assign ny_i = $signed(YDW'(cy_r)) + $signed({{(YDW-2){dy_i[1]}}, dy_i});
  assign nb_in_c = !nx_c[XDW-1] && ($unsigned(nx_c) < w_eff) &&
                   !ny_c[YDW-1] && ($unsigned(ny_c) < h_eff);
  assign addr_i   = addr_of(ny_i[YW-1:0], nx_i[XW-1:0]);
  assign addr_c   = addr_of(ny_c[YW-1:0], nx_c[XW-1:0]);
  assign addr_ctr = addr_of(cy_r, cx_r);

  assign seed_v  = ((dx_r == NB_Z) && (dy_r == NB_Z)) ? 10'sd0
                 : add_bias(bright_diff(mid_r, pix_rdata), seed_bias_r);
  assign grow_v  = add_bias(bright_diff(mid_r, pix_rdata), grow_bias_r);
  assign src_now = (lab_rdata != '0) ? lab_rdata : src_r;

  always_comb begin
    st_nxt        = st_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    mid_nxt       = mid_r;
    lab_nxt       = lab_r;
    src_nxt       = src_r;
    cnt_nxt       = cnt_r;
    l_nxt         = l_r;
    sum_nxt       = sum_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    clr_nxt       = clr_r;
    ran_nxt       = ran_r;
    inside_nxt    = inside_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_label_nxt = out_label_r;
    out_cnt_nxt   = out_cnt_r;
    dx_i          = dx_r;
    dy_i          = dy_r;

    pix_we    = 1'b0;
    pix_waddr = addr_of(YW'(in_row_index), XW'(in_col));
    pix_wdata = {in_red, in_green, in_blue};
    pix_raddr = addr_i;
    lab_we    = 1'b0;
    lab_waddr = addr_ctr;
    lab_wdata = lab_r;
    lab_raddr = addr_i;
    tal_we    = 1'b0;
    tal_waddr = lab_r[TW-1:0];
    tal_wdata = tal_rdata + CW'(1);
    tal_raddr = lab_r[TW-1:0];
    q_we      = 1'b0;
    q_waddr   = tail_r[AW-1:0];
    q_wdata   = {cy_r, cx_r};
    q_raddr   = head_r[AW-1:0];

    case (st_r)
      S_IDLE: begin
        lab_raddr = addr_of(YW'(in_row_index), XW'(in_col));
        if (in_fire) begin
          inside_nxt = in_inside;
          case (cmd_t'(in_cmd))
            CMD_RUN: begin
              clr_nxt = '0;
              st_nxt  = S_CLEAR;
            end
            CMD_READ: st_nxt = S_READ;
            CMD_LOAD: begin
              pix_we        = in_inside;
              out_valid_nxt = 1'b1;
              out_label_nxt = '0;
              out_cnt_nxt   = '0;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_label_nxt = '0;
              out_cnt_nxt   = '0;
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_label_nxt = (inside_r && ran_r) ? lab_rdata : '0;
        out_cnt_nxt   = '0;
        st_nxt        = S_IDLE;
      end
      S_CLEAR: begin
        lab_we    = (CW'(clr_r) < CW'(SD));
        lab_waddr = clr_r[AW-1:0];
        lab_wdata = '0;
        tal_we    = ((KW+1)'(clr_r) < (KW+1)'(TALLY_DEPTH));
        tal_waddr = clr_r[TW-1:0];
        tal_wdata = '0;
        cnt_nxt   = '0;
        ran_nxt   = 1'b1;
        clr_nxt   = clr_r + KW'(1);
        if (clr_r == KW'(CLR_N - 1)) begin
          cx_nxt = XW'(1);
          cy_nxt = YW'(1);
          if (w_eff < XDW'(3) || h_eff < YDW'(3)) begin
            st_nxt = S_DONE;
          end else begin
            st_nxt = S_SEED_MID;
          end
        end
      end
      S_SEED_MID: begin
        pix_raddr = addr_ctr;
        src_nxt   = '0;
        st_nxt    = S_SEED_MIDW;
      end
      S_SEED_MIDW: begin
        mid_nxt = pix_rdata;
        dx_i    = NB_M1;
        dy_i    = NB_M1;
        dx_nxt  = NB_M1;
        dy_nxt  = NB_M1;
        st_nxt  = S_SEED_EVAL;
      end
      S_SEED_EVAL: begin
        dx_i = dx_adv;
        dy_i = dy_adv;
        if (seed_v < 0) begin
          cx_nxt = cx_adv;
          cy_nxt = cy_adv;
          st_nxt = scan_end ? S_PRE_RD : S_SEED_MID;
        end else if (!nb_last) begin
          src_nxt = src_now;
          dx_nxt  = dx_adv;
          dy_nxt  = dy_adv;
        end else if (src_now != '0) begin
          lab_we    = 1'b1;
          lab_wdata = src_now;
          lab_nxt   = src_now;
          tal_raddr = src_now[TW-1:0];
          st_nxt    = S_TINC;
        end else if (cnt_r < LABEL_LIMIT) begin
          cnt_nxt   = cnt_r + 16'd1;
          lab_we    = 1'b1;
          lab_wdata = cnt_r + 16'd1;
          lab_nxt   = cnt_r + 16'd1;
          tal_raddr = TW'(cnt_r + 16'd1);
          st_nxt    = S_TINC;
        end else begin
          cx_nxt = cx_adv;
          cy_nxt = cy_adv;
          st_nxt = scan_end ? S_PRE_RD : S_SEED_MID;
        end
        if (st_nxt == S_PRE_RD) begin
          l_nxt   = 16'd1;
          sum_nxt = '0;
          if (cnt_r == '0) begin
            cx_nxt = XW'(1);
            cy_nxt = YW'(1);
            st_nxt = S_FILL_RD;
          end
        end
      end
      S_TINC: begin
        tal_we = 1'b1;
        cx_nxt = cx_adv;
        cy_nxt = cy_adv;
        l_nxt  = 16'd1;
        sum_nxt = '0;
        st_nxt = scan_end ? S_PRE_RD : S_SEED_MID;
      end
      S_PRE_RD: begin
        tal_raddr = l_r[TW-1:0];
        st_nxt    = S_PRE_WR;
      end
      S_PRE_WR: begin
        tal_we    = 1'b1;
        tal_waddr = l_r[TW-1:0];
        tal_wdata = sum_r;
        sum_nxt   = sum_r + tal_rdata;
        if (l_r == cnt_r) begin
          cx_nxt = XW'(1);
          cy_nxt = YW'(1);
          st_nxt = S_FILL_RD;
        end else begin
          l_nxt  = l_r + 16'd1;
          st_nxt = S_PRE_RD;
        end
      end
      S_FILL_RD: begin
        lab_raddr = addr_ctr;
        tail_nxt  = sum_r;
        head_nxt  = '0;
        st_nxt    = S_FILL_LAB;
      end
      S_FILL_LAB: begin
        lab_nxt   = lab_rdata;
        tal_raddr = lab_rdata[TW-1:0];
        if (lab_rdata != '0) begin
          st_nxt = S_FILL_WR;
        end else begin
          cx_nxt = cx_adv;
          cy_nxt = cy_adv;
          st_nxt = scan_end ? S_FL_Q : S_FILL_RD;
        end
      end
      S_FILL_WR: begin
        q_we    = 1'b1;
        q_waddr = tal_rdata[AW-1:0];
        tal_we  = 1'b1;
        cx_nxt  = cx_adv;
        cy_nxt  = cy_adv;
        st_nxt  = scan_end ? S_FL_Q : S_FILL_RD;
      end
      S_FL_Q: begin
        if (head_r < tail_r) begin
          head_nxt = head_r + CW'(1);
          st_nxt   = S_FL_C;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_FL_C: begin
        cx_nxt    = q_rdata[XW-1:0];
        cy_nxt    = q_rdata[QW-1:XW];
        pix_raddr = addr_of(q_rdata[QW-1:XW], q_rdata[XW-1:0]);
        lab_raddr = addr_of(q_rdata[QW-1:XW], q_rdata[XW-1:0]);
        st_nxt    = S_FL_CW;
      end
      S_FL_CW: begin
        mid_nxt = pix_rdata;
        lab_nxt = lab_rdata;
        dx_nxt  = NB_M1;
        dy_nxt  = NB_M1;
        st_nxt  = S_FL_NB;
      end
      S_FL_NB: begin
        if (nb_in_c) begin
          st_nxt = S_FL_EV;
        end else if (nb_last) begin
          st_nxt = S_FL_Q;
        end else begin
          dx_nxt = dx_adv;
          dy_nxt = dy_adv;
        end
      end
      S_FL_EV: begin
        if (lab_rdata == '0 && grow_v >= 0 &&
            grow_v < $signed({1'b0, edge_limit_r}) && tail_r < CW'(SD)) begin
          lab_we    = 1'b1;
          lab_waddr = addr_c;
          q_we      = 1'b1;
          q_wdata   = {ny_c[YW-1:0], nx_c[XW-1:0]};
          tail_nxt  = tail_r + CW'(1);
        end
        if (nb_last) begin
          st_nxt = S_FL_Q;
        end else begin
          dx_nxt = dx_adv;
          dy_nxt = dy_adv;
          st_nxt = S_FL_NB;
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_label_nxt = '0;
        out_cnt_nxt   = cnt_r;
        st_nxt        = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      img_w_r      <= RST_IMAGE_WIDTH;
      img_h_r      <= RST_IMAGE_HEIGHT;
      seed_bias_r  <= '0;
      grow_bias_r  <= '0;
      edge_limit_r <= RST_EDGE_LIMIT;
      cnt_r        <= '0;
      ran_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      clr_r        <= '0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      ran_r       <= ran_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      clr_r       <= clr_nxt;
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_IMAGE_WIDTH:  img_w_r      <= cfg_data;
          REG_IMAGE_HEIGHT: img_h_r      <= cfg_data;
          REG_SEED_BIAS:    seed_bias_r  <= cfg_data;
          REG_GROW_BIAS:    grow_bias_r  <= cfg_data;
          REG_EDGE_LIMIT:   edge_limit_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    mid_r       <= mid_nxt;
    lab_r       <= lab_nxt;
    src_r       <= src_nxt;
    l_r         <= l_nxt;
    sum_r       <= sum_nxt;
    inside_r    <= inside_nxt;
    out_label_r <= out_label_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

`ifndef NO_ASSERTIONS
  a_fire_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> st_r == S_IDLE) else $error("transaction accepted while busy");
  a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_cmd == CMD_RUN |=> st_r == S_CLEAR) else $error("run did not clear");
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_FL_Q |-> head_r <= tail_r) else $error("queue head passed tail");
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DONE |=> out_valid_r && st_r == S_IDLE) else $error("run result lost");
`endif

endmodule
